[rtl/arm_forward_kinematics_unit_assert.svh]
// Assertion macros used by the arm kinematics top module.
`ifndef ARM_FORWARD_KINEMATICS_UNIT_ASSERT_SVH
`define ARM_FORWARD_KINEMATICS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define AFK_ASSERT_IMPLY(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("afk assertion failed");

// Delayed implication, with the delay given by the n argument.
`define AFK_ASSERT_DELAY(label, clk, dis, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> ##n (cons)) \
    else $error("afk delayed assertion failed");

`endif

[rtl/afk_pkg.sv]
// Shared constants and types for the arm kinematics unit.
package afk_pkg;

  localparam int STEPS_W = 12;
  localparam int RW      = 16;
  localparam int ZW      = 34;
  localparam int OUT_W   = 15;
  localparam int CFG_W   = 12;
  localparam int ATAN_N  = 24;

  localparam logic [63:0] CORDIC_GAIN_Q30 = 64'd652032874;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [3:0] {
    CFG_UPPER_LINK     = 4'd0,
    CFG_FOREARM        = 4'd1,
    CFG_GRIPPER_OFFSET = 4'd2,
    CFG_GRIPPER_TILT   = 4'd3
  } cfg_reg_t;

endpackage

[rtl/afk_reduce.sv]
// Reduces a joint angle modulo the steps per turn in two stages.
module afk_reduce
  import afk_pkg::*;
#(
  parameter int STEPS_PER_TURN = 4096
) (
  input  logic               clk,
  input  logic [STEPS_W-1:0] steps,
  output logic [RW-1:0]      rem_r
);

  localparam logic [63:0] TURN  = 64'(STEPS_PER_TURN);
  localparam logic [63:0] RECIP = ((64'd1 << 30) + TURN - 64'd1) / TURN;
  localparam int PW = STEPS_W + 23;

  logic [PW-1:0]      prod_r;
  logic [STEPS_W-1:0] steps_r;
  logic [3:0]         quo;
  logic [RW:0]        sub;

  always_comb begin
    quo = 4'(prod_r >> 30);
    sub = (RW+1)'(steps_r) - (RW+1)'(64'(quo) * TURN);
  end

  always_ff @(posedge clk) begin
    prod_r  <= PW'(64'(steps) * RECIP);
    steps_r <= steps;
    rem_r   <= sub[RW-1:0];
  end

endmodule

[rtl/afk_phase.sv]
// Converts reduced steps to a 32-bit phase and folds it into a half turn.
module afk_phase
  import afk_pkg::*;
#(
  parameter int STEPS_PER_TURN = 4096
) (
  input  logic                 clk,
  input  logic [RW-1:0]        steps,
  output logic signed [ZW-1:0] z_r,
  output logic                 flip_r
);

  localparam logic [63:0] TURN = 64'(STEPS_PER_TURN);
  localparam logic [63:0] A    = (64'd1 << 32) / TURN;
  localparam logic [63:0] B    = (64'd1 << 32) % TURN;
  localparam logic [63:0] MR   = (64'd1 << 34) / TURN;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(64'd1 << 30);
  localparam logic signed [ZW-1:0] HALF    = ZW'(64'd1 << 31);

  logic [31:0] ra_r, rb_r, ra2_r, rb2_r, est_r, phase_r;
  logic [63:0] rem;
  logic        inc;
  logic signed [ZW-1:0] zs;

  always_comb begin
    rem = 64'(rb2_r) - 64'(est_r) * TURN;
    inc = (rem >= TURN);
    zs  = {{(ZW-32){phase_r[31]}}, phase_r};
  end

  always_ff @(posedge clk) begin
    ra_r    <= 32'(64'(steps) * A);
    rb_r    <= 32'(64'(steps) * B);
    // quotient estimate may fall one short; fix it in the next stage
    est_r   <= 32'((64'(rb_r) * MR) >> 34);
    ra2_r   <= ra_r;
    rb2_r   <= rb_r;
    phase_r <= ra2_r + est_r + 32'(inc);
    if (zs > QUARTER) begin
      z_r    <= zs - HALF;
      flip_r <= 1'b1;
    end else if (zs < -QUARTER) begin
      z_r    <= zs + HALF;
      flip_r <= 1'b1;
    end else begin
      z_r    <= zs;
      flip_r <= 1'b0;
    end
  end

endmodule

[rtl/afk_cordic_cell.sv]
// One rotation-mode CORDIC iteration with registered outputs.
module afk_cordic_cell
  import afk_pkg::*;
#(
  parameter int XW    = 19,
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic                 flip_i,
  output logic signed [XW-1:0] x_r,
  output logic signed [XW-1:0] y_r,
  output logic signed [ZW-1:0] z_r,
  output logic                 flip_r
);

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] ang;

  always_comb begin
    xs  = x_i >>> STAGE;
    ys  = y_i >>> STAGE;
    ang = signed'(ZW'(ATAN_TURN32[STAGE]));
  end

  always_ff @(posedge clk) begin
    flip_r <= flip_i;
    if (!z_i[ZW-1]) begin
      x_r <= x_i - ys;
      y_r <= y_i + xs;
      z_r <= z_i - ang;
    end else begin
      x_r <= x_i + ys;
      y_r <= y_i - xs;
      z_r <= z_i + ang;
    end
  end

endmodule

[rtl/afk_combine.sv]
// Combines link sines and cosines into the tip position and rounds it.
module afk_combine
  import afk_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int XW        = 19
) (
  input  logic                    clk,
  input  logic signed [XW-1:0]    x_i [4],
  input  logic signed [XW-1:0]    y_i [4],
  input  logic                    flip_i [4],
  input  logic [CFG_W-1:0]        link_len,
  input  logic [CFG_W-1:0]        fore_len,
  input  logic [CFG_W-1:0]        grip_len,
  output logic signed [OUT_W-1:0] pos_x_r,
  output logic signed [OUT_W-1:0] pos_y_r,
  output logic signed [OUT_W-1:0] pos_z_r
);

  localparam int PW = XW + 14;
  localparam int SW = PW + 2;
  localparam int MW = SW + XW;

  logic signed [XW-1:0] sv [4];
  logic signed [XW-1:0] cv [4];
  logic signed [XW-1:0] cb1_r, sb1_r, st1_r, ct1_r, cb2_r, sb2_r, cb3_r, sb3_r;
  logic signed [XW:0]   dc1_r, ss1_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, q1_r, q2_r, q3_r;
  logic signed [SW-1:0] w_r, zz_r;
  logic signed [MW-1:0] x_r, y_r, z4_r;
  logic signed [CFG_W:0] l_s, r_s, g_s;

  function automatic logic [OUT_W-1:0] rnd(input logic signed [MW-1:0] v, input int sh);
    logic [MW-1:0] mag;
    logic [MW-1:0] rr;
    mag = v[MW-1] ? MW'(-v) : MW'(v);
    rr  = (mag + (MW'(1) << (sh - 1))) >> sh;
    return OUT_W'(v[MW-1] ? -rr : rr);
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sv[i] = flip_i[i] ? -y_i[i] : y_i[i];
      cv[i] = flip_i[i] ? -x_i[i] : x_i[i];
    end
    l_s = signed'({1'b0, link_len});
    r_s = signed'({1'b0, fore_len});
    g_s = signed'({1'b0, grip_len});
  end

  always_ff @(posedge clk) begin
    // lanes: base, shoulder, elbow difference, tilt
    cb1_r <= cv[0];
    sb1_r <= sv[0];
    st1_r <= sv[3];
    ct1_r <= cv[3];
    dc1_r <= (XW+1)'(cv[2]) - (XW+1)'(cv[1]);
    ss1_r <= (XW+1)'(sv[1]) + (XW+1)'(sv[2]);

    p1_r  <= PW'(dc1_r) * PW'(l_s);
    p2_r  <= PW'(ct1_r) * PW'(g_s);
    p3_r  <= PW'(st1_r) * PW'(r_s);
    q1_r  <= PW'(ss1_r) * PW'(l_s);
    q2_r  <= PW'(st1_r) * PW'(g_s);
    q3_r  <= PW'(ct1_r) * PW'(r_s);
    cb2_r <= cb1_r;
    sb2_r <= sb1_r;

    w_r   <= SW'(p1_r) + SW'(p2_r) - SW'(p3_r);
    zz_r  <= SW'(q1_r) - SW'(q2_r) - SW'(q3_r);
    cb3_r <= cb2_r;
    sb3_r <= sb2_r;

    x_r   <= -(MW'(cb3_r) * MW'(w_r));
    y_r   <= MW'(sb3_r) * MW'(w_r);
    z4_r  <= MW'(zz_r);

    pos_x_r <= signed'(rnd(x_r, 2 * FRAC_BITS));
    pos_y_r <= signed'(rnd(y_r, 2 * FRAC_BITS));
    pos_z_r <= signed'(rnd(z4_r, FRAC_BITS));
  end

endmodule

[rtl/arm_forward_kinematics_unit.sv]
// Throughput: one pose per cycle; busy stays low and a pose may follow every cycle.
// Latency is set by the CORDIC cell chain, one cell per fraction bit, plus the
// reduce, phase and combine stages.
// Reset clears the link, forearm, gripper offset and tilt registers and drops every pose in flight.
// Results are strobed for one cycle; the receiver cannot stall.
module arm_forward_kinematics_unit
  import afk_pkg::*;
#(
  parameter int STEPS_PER_TURN = 4096,
  parameter int FRAC_BITS      = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [STEPS_W-1:0]      in_base_angle,
  input  logic [STEPS_W-1:0]      in_shoulder_angle,
  input  logic [STEPS_W-1:0]      in_elbow_angle,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_pos_x,
  output logic signed [OUT_W-1:0] out_pos_y,
  output logic signed [OUT_W-1:0] out_pos_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [3:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

`include "arm_forward_kinematics_unit_assert.svh"

  localparam int XW  = FRAC_BITS + 3;
  localparam int LAT = FRAC_BITS + 12;
  localparam logic [63:0] TURN = 64'(STEPS_PER_TURN);
  localparam logic [63:0] GAIN =
    (CORDIC_GAIN_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  logic [CFG_W-1:0] link_r, fore_r, grip_r, tilt_r;
  logic [LAT-1:0]   vld_r;

  logic [RW-1:0] rb, rs, re, rt;
  logic [RW-1:0] b1_r, s1_r, d1_r, t1_r;
  logic [RW:0]   dsub;
  logic [RW-1:0] lane_in [4];

  logic signed [XW-1:0] cx [4][FRAC_BITS+1];
  logic signed [XW-1:0] cy [4][FRAC_BITS+1];
  logic signed [ZW-1:0] cz [4][FRAC_BITS+1];
  logic                 cf [4][FRAC_BITS+1];
  logic signed [XW-1:0] fx [4];
  logic signed [XW-1:0] fy [4];
  logic                 ff [4];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0;
      fore_r <= '0;
      grip_r <= '0;
      tilt_r <= '0;
      vld_r  <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_UPPER_LINK:     link_r <= cfg_data;
          CFG_FOREARM:        fore_r <= cfg_data;
          CFG_GRIPPER_OFFSET: grip_r <= cfg_data;
          CFG_GRIPPER_TILT:   tilt_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  afk_reduce #(.STEPS_PER_TURN(STEPS_PER_TURN)) u_red_b (
    .clk(clk), .steps(in_base_angle), .rem_r(rb));
  afk_reduce #(.STEPS_PER_TURN(STEPS_PER_TURN)) u_red_s (
    .clk(clk), .steps(in_shoulder_angle), .rem_r(rs));
  afk_reduce #(.STEPS_PER_TURN(STEPS_PER_TURN)) u_red_e (
    .clk(clk), .steps(in_elbow_angle), .rem_r(re));
  afk_reduce #(.STEPS_PER_TURN(STEPS_PER_TURN)) u_red_t (
    .clk(clk), .steps(tilt_r), .rem_r(rt));

  // elbow relative to shoulder, wrapped into one turn
  assign dsub = (RW+1)'(re) - (RW+1)'(rs);

  always_ff @(posedge clk) begin
    b1_r <= rb;
    s1_r <= rs;
    t1_r <= rt;
    d1_r <= dsub[RW] ? RW'(dsub + (RW+1)'(TURN)) : dsub[RW-1:0];
  end

  assign lane_in[0] = b1_r;
  assign lane_in[1] = s1_r;
  assign lane_in[2] = d1_r;
  assign lane_in[3] = t1_r;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    afk_phase #(.STEPS_PER_TURN(STEPS_PER_TURN)) u_phase (
      .clk(clk), .steps(lane_in[l]), .z_r(cz[l][0]), .flip_r(cf[l][0]));

    assign cx[l][0] = XW'(GAIN);
    assign cy[l][0] = '0;

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
      afk_cordic_cell #(.XW(XW), .STAGE(k)) u_cell (
        .clk(clk),
        .x_i(cx[l][k]), .y_i(cy[l][k]), .z_i(cz[l][k]), .flip_i(cf[l][k]),
        .x_r(cx[l][k+1]), .y_r(cy[l][k+1]), .z_r(cz[l][k+1]), .flip_r(cf[l][k+1]));
    end

    assign fx[l] = cx[l][FRAC_BITS];
    assign fy[l] = cy[l][FRAC_BITS];
    assign ff[l] = cf[l][FRAC_BITS];
  end

  afk_combine #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_combine (
    .clk(clk),
    .x_i(fx), .y_i(fy), .flip_i(ff),
    .link_len(link_r), .fore_len(fore_r), .grip_len(grip_r),
    .pos_x_r(out_pos_x), .pos_y_r(out_pos_y), .pos_z_r(out_pos_z));

  `AFK_ASSERT_IMPLY(a_out_has_start, clk, !rst_n, out_valid, $past(start && !busy, LAT))
  `AFK_ASSERT_DELAY(a_start_gives_out, clk, !rst_n, start && !busy, LAT, out_valid)
  `AFK_ASSERT_DELAY(a_reset_drops, clk, 1'b0, !rst_n, 1, !out_valid)

endmodule
